// ----- rtl/dbsa_pkg.sv -----
// shared types, codes and zone-table functions of the sector allocator
package dbsa_pkg;

    // field widths fixed by the item format
    localparam int TRACK_W  = 6;
    localparam int SECTOR_W = 5;
    localparam int BITS_W   = 24;
    localparam int COUNT_W  = 8;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 18;
    localparam int CUM_W    = 10;
    localparam int ENTRY_W  = BITS_W + COUNT_W;

    // function codes
    localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TRACK = 2'd2;

    typedef logic [TRACK_W-1:0]  track_t;
    typedef logic [SECTOR_W-1:0] sector_t;
    typedef logic [BITS_W-1:0]   bits_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // sectors per track from the zone table
    function automatic sector_t sectors_on(input track_t t);
        sector_t n;
        if (t <= track_t'(17))
            n = sector_t'(21);
        else if (t <= track_t'(24))
            n = sector_t'(19);
        else if (t <= track_t'(30))
            n = sector_t'(18);
        else
            n = sector_t'(17);
        return n;
    endfunction

    // bits of the map that hold real sectors of the track
    function automatic bits_t sector_mask(input track_t t);
        bits_t m;
        m = (bits_t'(1) << sectors_on(t)) - bits_t'(1);
        return m;
    endfunction

    // sectors on all tracks below t, piecewise over the zones
    function automatic logic [CUM_W-1:0] sectors_before(input track_t t);
        logic [CUM_W-1:0] tt;
        logic [CUM_W-1:0] s;
        tt = CUM_W'(t);
        if (tt <= CUM_W'(18))
            s = (tt - CUM_W'(1)) * CUM_W'(21);
        else if (tt <= CUM_W'(25))
            s = CUM_W'(357) + (tt - CUM_W'(18)) * CUM_W'(19);
        else if (tt <= CUM_W'(31))
            s = CUM_W'(490) + (tt - CUM_W'(25)) * CUM_W'(18);
        else
            s = CUM_W'(598) + (tt - CUM_W'(31)) * CUM_W'(17);
        return s;
    endfunction

    // index of the lowest set bit
    function automatic sector_t lowest_set(input bits_t m);
        sector_t idx;
        idx = '0;
        for (int i = BITS_W - 1; i >= 0; i--)
        begin
            if (m[i])
                idx = sector_t'(i);
        end
        return idx;
    endfunction

endpackage

// ----- rtl/dbsa_ram.sv -----
// generic single write port ram with registered read
module dbsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 35
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/disk_bitmap_sector_allocator.sv -----
// sector allocator over a per-track free-sector bitmap held in a ram
// a load writes the track entry, a read waits for the registered ram read, and an
//   allocation searches with a one-track-a-cycle probe loop through the single ram read
//   port, then writes the updated entry back
// one item at a time: the next item is taken once the result is registered, a stalled result
//   holds the next one back; reset clears control and per-track valid flags, tracks read empty
module disk_bitmap_sector_allocator #(
    parameter int NUM_TRACKS     = 35,
    parameter int RESERVED_TRACK = 18
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [dbsa_pkg::FUNC_W-1:0]      func,
    input  logic [dbsa_pkg::TRACK_W-1:0]     track_number,
    input  logic [dbsa_pkg::BITS_W-1:0]      free_bits,
    input  logic [dbsa_pkg::COUNT_W-1:0]     free_total,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [dbsa_pkg::STATUS_W-1:0]    status,
    output logic [dbsa_pkg::TRACK_W-1:0]     alloc_track,
    output logic [dbsa_pkg::SECTOR_W-1:0]    alloc_sector,
    output logic [dbsa_pkg::OFFSET_W-1:0]    image_offset,
    output logic [dbsa_pkg::BITS_W-1:0]      track_bits,
    output logic [dbsa_pkg::COUNT_W-1:0]     track_free
);

    localparam int AW        = $clog2(NUM_TRACKS);
    localparam int DELTA_MAX = (RESERVED_TRACK - 1 > NUM_TRACKS - RESERVED_TRACK) ?
                               (RESERVED_TRACK - 1) : (NUM_TRACKS - RESERVED_TRACK);
    localparam int DW        = $clog2(DELTA_MAX + 2);
    localparam int CW        = dbsa_pkg::TRACK_W + 1;
    localparam int TW        = dbsa_pkg::TRACK_W;
    localparam int BW        = dbsa_pkg::BITS_W;
    localparam int NW        = dbsa_pkg::COUNT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [NUM_TRACKS-1:0]             valid_reg, valid_next;
    logic [DW-1:0]                     delta_reg, delta_next;
    logic                              side_reg, side_next;
    logic                              probe_vld_reg, probe_vld_next;
    logic                              probe_ent_reg, probe_ent_next;
    logic [TW-1:0]                     probe_trk_reg, probe_trk_next;
    logic                              out_valid_reg, out_valid_next;

    logic [dbsa_pkg::STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [TW-1:0]                     res_track_reg, res_track_next;
    logic [dbsa_pkg::SECTOR_W-1:0]     res_sector_reg, res_sector_next;
    logic [dbsa_pkg::OFFSET_W-1:0]     res_offset_reg, res_offset_next;
    logic [BW-1:0]                     res_bits_reg, res_bits_next;
    logic [NW-1:0]                     res_free_reg, res_free_next;

    logic [dbsa_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [TW-1:0]                     alloc_track_reg, alloc_track_next;
    logic [dbsa_pkg::SECTOR_W-1:0]     alloc_sector_reg, alloc_sector_next;
    logic [dbsa_pkg::OFFSET_W-1:0]     image_offset_reg, image_offset_next;
    logic [BW-1:0]                     track_bits_reg, track_bits_next;
    logic [NW-1:0]                     track_free_reg, track_free_next;

    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic [dbsa_pkg::ENTRY_W-1:0]      wr_data;
    logic [AW-1:0]                     rd_addr;
    logic [dbsa_pkg::ENTRY_W-1:0]      rd_data;

    logic                              trk_ok;
    logic [CW-1:0]                     dir_c, delta_c, cand;
    logic                              in_range, exhausted, issue;
    logic [BW-1:0]                     probe_map, masked, low_bit;
    logic [NW-1:0]                     probe_cnt;
    logic                              hit;
    logic [dbsa_pkg::CUM_W-1:0]        cum;

    // track entry store
    dbsa_ram #(
        .WIDTH (dbsa_pkg::ENTRY_W),
        .DEPTH (NUM_TRACKS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // candidate track of the search order
    always_comb
    begin
        trk_ok    = (track_number != '0) && (track_number <= TW'(NUM_TRACKS));
        dir_c     = CW'(RESERVED_TRACK);
        delta_c   = CW'(delta_reg);
        if (side_reg)
            cand = dir_c + delta_c;
        else
            cand = (dir_c > delta_c) ? (dir_c - delta_c) : '0;
        in_range  = (cand != '0) && (cand <= CW'(NUM_TRACKS));
        exhausted = delta_reg > DW'(DELTA_MAX);
        issue     = !exhausted && in_range;
    end

    // check of the entry read for the previous candidate
    always_comb
    begin
        probe_map = probe_ent_reg ? rd_data[dbsa_pkg::ENTRY_W-1:NW] : '0;
        probe_cnt = probe_ent_reg ? rd_data[NW-1:0] : '0;
        masked    = probe_map & dbsa_pkg::sector_mask(probe_trk_reg);
        low_bit   = masked & (~masked + BW'(1));
        hit       = probe_vld_reg && (masked != '0);
        cum       = dbsa_pkg::sectors_before(res_track_reg) +
                    dbsa_pkg::CUM_W'(res_sector_reg);
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        delta_next        = delta_reg;
        side_next         = side_reg;
        probe_vld_next    = 1'b0;
        probe_ent_next    = 1'b0;
        probe_trk_next    = probe_trk_reg;
        out_valid_next    = out_valid_reg;
        res_status_next   = res_status_reg;
        res_track_next    = res_track_reg;
        res_sector_next   = res_sector_reg;
        res_offset_next   = res_offset_reg;
        res_bits_next     = res_bits_reg;
        res_free_next     = res_free_reg;
        status_next       = status_reg;
        alloc_track_next  = alloc_track_reg;
        alloc_sector_next = alloc_sector_reg;
        image_offset_next = image_offset_reg;
        track_bits_next   = track_bits_reg;
        track_free_next   = track_free_reg;
        wr_en             = 1'b0;
        wr_addr           = AW'(track_number - TW'(1));
        wr_data           = {free_bits, free_total};
        rd_addr           = AW'(track_number - TW'(1));

        // output register drains
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = dbsa_pkg::ST_OK;
                    res_track_next  = '0;
                    res_sector_next = '0;
                    res_offset_next = '0;
                    res_bits_next   = '0;
                    res_free_next   = '0;
                    unique case (func)
                        dbsa_pkg::FN_ALLOC:
                        begin
                            delta_next = DW'(1);
                            side_next  = 1'b0;
                            state_next = S_SEARCH;
                        end
                        dbsa_pkg::FN_LOAD:
                        begin
                            state_next = S_DONE;
                            if (trk_ok)
                            begin
                                wr_en      = 1'b1;
                                valid_next[AW'(track_number - TW'(1))] = 1'b1;
                                res_bits_next = free_bits;
                                res_free_next = free_total;
                            end
                            else
                                res_status_next = dbsa_pkg::ST_BAD_TRACK;
                        end
                        default:
                        begin
                            // read, also for the unused code
                            if (trk_ok)
                            begin
                                probe_ent_next = valid_reg[AW'(track_number - TW'(1))];
                                state_next     = S_RDWAIT;
                            end
                            else
                            begin
                                res_status_next = dbsa_pkg::ST_BAD_TRACK;
                                state_next      = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                res_bits_next = probe_map;
                res_free_next = probe_cnt;
                state_next    = S_DONE;
            end
            S_SEARCH:
            begin
                // issue next candidate read
                rd_addr        = AW'(cand - CW'(1));
                probe_vld_next = issue;
                probe_ent_next = issue && valid_reg[AW'(cand - CW'(1))];
                probe_trk_next = TW'(cand);
                priority if (hit)
                begin
                    res_track_next  = probe_trk_reg;
                    res_sector_next = dbsa_pkg::lowest_set(masked);
                    res_bits_next   = probe_map & ~low_bit;
                    res_free_next   = probe_cnt - NW'(1);
                    probe_vld_next  = 1'b0;
                    state_next      = S_COMMIT;
                end
                else if (exhausted && !probe_vld_reg)
                begin
                    res_status_next = dbsa_pkg::ST_FULL;
                    state_next      = S_DONE;
                end
                else if (!exhausted)
                begin
                    if (side_reg)
                    begin
                        delta_next = delta_reg + DW'(1);
                        side_next  = 1'b0;
                    end
                    else
                        side_next = 1'b1;
                end
            end
            S_COMMIT:
            begin
                wr_en           = 1'b1;
                wr_addr         = AW'(res_track_reg - TW'(1));
                wr_data         = {res_bits_reg, res_free_reg};
                valid_next[AW'(res_track_reg - TW'(1))] = 1'b1;
                res_offset_next = {cum, 8'h00};
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_status_reg;
                    alloc_track_next  = res_track_reg;
                    alloc_sector_next = res_sector_reg;
                    image_offset_next = res_offset_reg;
                    track_bits_next   = res_bits_reg;
                    track_free_next   = res_free_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            probe_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            probe_vld_reg <= probe_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        delta_reg        <= delta_next;
        side_reg         <= side_next;
        probe_ent_reg    <= probe_ent_next;
        probe_trk_reg    <= probe_trk_next;
        res_status_reg   <= res_status_next;
        res_track_reg    <= res_track_next;
        res_sector_reg   <= res_sector_next;
        res_offset_reg   <= res_offset_next;
        res_bits_reg     <= res_bits_next;
        res_free_reg     <= res_free_next;
        status_reg       <= status_next;
        alloc_track_reg  <= alloc_track_next;
        alloc_sector_reg <= alloc_sector_next;
        image_offset_reg <= image_offset_next;
        track_bits_reg   <= track_bits_next;
        track_free_reg   <= track_free_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign alloc_track  = alloc_track_reg;
    assign alloc_sector = alloc_sector_reg;
    assign image_offset = image_offset_reg;
    assign track_bits   = track_bits_reg;
    assign track_free   = track_free_reg;

    // an accepted item always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted item did not start the sequencer");

    // the search never probes the directory track or a track off the disk
    assert property (@(posedge clk) disable iff (!rst_n)
        probe_vld_reg |-> (probe_trk_reg != TW'(RESERVED_TRACK)) && (probe_trk_reg != '0) &&
                          (probe_trk_reg <= TW'(NUM_TRACKS)))
        else $error("search probed a forbidden track");

    // the store is written only by a load or an allocation commit
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_IDLE) || (state_reg == S_COMMIT))
        else $error("unexpected store write");

    // a failed item carries no allocation
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != dbsa_pkg::ST_OK) |->
            (alloc_track == '0) && (image_offset == '0) && (track_bits == '0))
        else $error("failed item carries allocation data");

    // a new result is loaded only once the previous one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(track_bits))
        else $error("pending result overwritten");

endmodule
